>>> hdl/bpru_pkg.sv
// Shared types, constants and helper functions for the BMP pixel row unpacker.
`timescale 1ns / 1ps

package bpru_pkg;

  // Sizes of the row logic and the palette store.
  localparam int unsigned MaxWidth     = 4096;
  localparam int unsigned PaletteBytes = 1024;
  localparam int unsigned PalAddrW     = 10;
  localparam int unsigned PalSpanW     = 11;
  localparam int unsigned WidthW       = 13;
  localparam int unsigned ByteCntW     = 14;
  localparam int unsigned RowLenW      = 15;
  localparam int unsigned CfgDataW     = 13;
  localparam int unsigned CfgIdxW      = 2;

  // Pixel formats selected by the mode register.
  typedef enum logic [1:0] {
    MODE_INDEXED = 2'd0,
    MODE_RGB565  = 2'd1,
    MODE_BGR24   = 2'd2,
    MODE_BGRA32  = 2'd3
  } pixel_mode_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_PIXEL_MODE     = 2'd0,
    REG_IMAGE_WIDTH    = 2'd1,
    REG_PALETTE_STRIDE = 2'd2
  } cfg_reg_e;

  // Kind of an input transaction, carried in tuser.
  typedef enum logic {
    OP_PAL_WRITE  = 1'b0,
    OP_IMAGE_BYTE = 1'b1
  } opcode_e;

  // What the row tracker reports for the byte that is being accepted.
  typedef struct packed {
    logic        emit;
    logic        row_end;
    pixel_mode_e mode;
    logic [23:0] bytes;
  } pix_info_t;

  // Widen a 5-bit channel to 8 bits, repeating its lowest bit downward.
  function automatic logic [7:0] widen5(input logic [4:0] v);
    widen5 = {v, {3{v[0]}}};
  endfunction

  // Widen a 6-bit channel to 8 bits, repeating its lowest bit downward.
  function automatic logic [7:0] widen6(input logic [5:0] v);
    widen6 = {v, {2{v[0]}}};
  endfunction

endpackage

>>> hdl/bpru_pal_ram.sv
// Palette byte store: 1024 x 8 memory with one write port and one registered read port.
`timescale 1ns / 1ps

module bpru_pal_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [bpru_pkg::PalAddrW-1:0] waddr_i,
  input  logic [7:0]                    wdata_i,
  input  logic                          re_i,
  input  logic [bpru_pkg::PalAddrW-1:0] raddr_i,
  output logic [7:0]                    rdata_o
);

  logic [7:0] mem_q [bpru_pkg::PaletteBytes];
  logic [7:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds while the read is not enabled.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/bpru_row_ctrl.sv
// Configuration registers and row position tracking: pads, pixel assembly and row ends.
`timescale 1ns / 1ps

module bpru_row_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bpru_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bpru_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          step_i,
  input  logic [7:0]                    data_i,
  output bpru_pkg::pix_info_t           info_o,
  output logic [2:0]                    stride_o
);

  bpru_pkg::pixel_mode_e               mode_q;
  logic [bpru_pkg::WidthW-1:0]         width_q;
  logic [2:0]                          stride_q;
  logic [bpru_pkg::ByteCntW-1:0]       byte_cnt_q, byte_cnt_d;
  logic [bpru_pkg::WidthW-1:0]         pix_cnt_q, pix_cnt_d;
  logic [1:0]                          bip_q, bip_d;
  logic [23:0]                         pend_q, pend_d;

  logic [bpru_pkg::WidthW-1:0]         eff_w;
  logic [bpru_pkg::RowLenW-1:0]        pix_bytes;
  logic [bpru_pkg::RowLenW-1:0]        row_len;
  logic [bpru_pkg::RowLenW-1:0]        byte_inc;
  logic [bpru_pkg::ByteCntW-1:0]       pix_inc;
  logic                                in_pixels;
  logic                                pix_done;
  logic                                row_wrap;
  logic                                cfg_restart;
  logic [23:0]                         pend_next;

  // Width as used: zero counts as one, large values saturate.
  always_comb begin
    eff_w = width_q;
    if (width_q == '0) begin
      eff_w = bpru_pkg::WidthW'(1);
    end else if (width_q > bpru_pkg::WidthW'(bpru_pkg::MaxWidth)) begin
      eff_w = bpru_pkg::WidthW'(bpru_pkg::MaxWidth);
    end
  end

  // Pixel bytes per row for the current mode, then padded to a multiple of four.
  always_comb begin
    case (mode_q)
      bpru_pkg::MODE_INDEXED: pix_bytes = bpru_pkg::RowLenW'(eff_w);
      bpru_pkg::MODE_RGB565:  pix_bytes = bpru_pkg::RowLenW'(eff_w) << 1;
      bpru_pkg::MODE_BGR24:   pix_bytes = (bpru_pkg::RowLenW'(eff_w) << 1)
                                          + bpru_pkg::RowLenW'(eff_w);
      default:                pix_bytes = bpru_pkg::RowLenW'(eff_w) << 2;
    endcase
    row_len = (pix_bytes + bpru_pkg::RowLenW'(3)) & ~bpru_pkg::RowLenW'(3);
  end

  // Position within the row and the pixel.
  assign byte_inc  = bpru_pkg::RowLenW'(byte_cnt_q) + bpru_pkg::RowLenW'(1);
  assign pix_inc   = bpru_pkg::ByteCntW'(pix_cnt_q) + bpru_pkg::ByteCntW'(1);
  assign in_pixels = bpru_pkg::RowLenW'(byte_cnt_q) < pix_bytes;
  assign pix_done  = bip_q >= 2'(mode_q);
  assign row_wrap  = byte_inc >= row_len;

  // Merge the incoming byte into the first three bytes of the pixel.
  always_comb begin
    pend_next = pend_q;
    case (bip_q)
      2'd0:    pend_next[7:0]   = pend_q[7:0]   | data_i;
      2'd1:    pend_next[15:8]  = pend_q[15:8]  | data_i;
      2'd2:    pend_next[23:16] = pend_q[23:16] | data_i;
      default: pend_next = pend_q;
    endcase
  end

  // Next state of the row counters.
  assign cfg_restart = cfg_we_i && ((cfg_idx_i == bpru_pkg::REG_PIXEL_MODE) ||
                                    (cfg_idx_i == bpru_pkg::REG_IMAGE_WIDTH));

  always_comb begin
    byte_cnt_d = byte_cnt_q;
    pix_cnt_d  = pix_cnt_q;
    bip_d      = bip_q;
    pend_d     = pend_q;
    if (cfg_restart) begin
      byte_cnt_d = '0;
      pix_cnt_d  = '0;
      bip_d      = '0;
      pend_d     = '0;
    end else if (step_i) begin
      if (in_pixels) begin
        if (pix_done) begin
          pix_cnt_d = pix_cnt_q + bpru_pkg::WidthW'(1);
          bip_d     = '0;
          pend_d    = '0;
        end else begin
          bip_d  = bip_q + 2'd1;
          pend_d = pend_next;
        end
      end
      byte_cnt_d = byte_inc[bpru_pkg::ByteCntW-1:0];
      if (row_wrap) begin
        byte_cnt_d = '0;
        pix_cnt_d  = '0;
        bip_d      = '0;
        pend_d     = '0;
      end
    end
  end

  // Configuration and row state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= bpru_pkg::MODE_BGR24;
      width_q    <= bpru_pkg::WidthW'(1);
      stride_q   <= 3'd4;
      byte_cnt_q <= '0;
      pix_cnt_q  <= '0;
      bip_q      <= '0;
      pend_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          bpru_pkg::REG_PIXEL_MODE:
            mode_q <= bpru_pkg::pixel_mode_e'(cfg_data_i[1:0]);
          bpru_pkg::REG_IMAGE_WIDTH:
            width_q <= cfg_data_i[bpru_pkg::WidthW-1:0];
          bpru_pkg::REG_PALETTE_STRIDE:
            stride_q <= cfg_data_i[2:0];
          default: ;
        endcase
      end
      byte_cnt_q <= byte_cnt_d;
      pix_cnt_q  <= pix_cnt_d;
      bip_q      <= bip_d;
      pend_q     <= pend_d;
    end
  end

  // Report for the byte being accepted.
  assign info_o.emit    = step_i && in_pixels && pix_done;
  assign info_o.row_end = pix_inc >= bpru_pkg::ByteCntW'(eff_w);
  assign info_o.mode    = mode_q;
  assign info_o.bytes   = pend_next;
  assign stride_o       = stride_q;

endmodule

>>> hdl/bpru_pix_decode.sv
// Color conversion of one assembled pixel to 8-bit red, green and blue.
`timescale 1ns / 1ps

module bpru_pix_decode (
  input  bpru_pkg::pixel_mode_e mode_i,
  input  logic [23:0]           bytes_i,
  input  logic [7:0]            pal_b_i,
  input  logic [7:0]            pal_g_i,
  input  logic [7:0]            pal_r_i,
  input  logic [2:0]            pal_zero_i,
  output logic [7:0]            red_o,
  output logic [7:0]            green_o,
  output logic [7:0]            blue_o
);

  logic [15:0] c565;

  assign c565 = bytes_i[15:0];

  // Select the conversion for the pixel format.
  always_comb begin
    case (mode_i)
      bpru_pkg::MODE_INDEXED: begin
        // Palette bytes past the end of the store read as zero.
        blue_o  = pal_zero_i[0] ? 8'd0 : pal_b_i;
        green_o = pal_zero_i[1] ? 8'd0 : pal_g_i;
        red_o   = pal_zero_i[2] ? 8'd0 : pal_r_i;
      end
      bpru_pkg::MODE_RGB565: begin
        red_o   = bpru_pkg::widen5(c565[15:11]);
        green_o = bpru_pkg::widen6(c565[10:5]);
        blue_o  = bpru_pkg::widen5(c565[4:0]);
      end
      default: begin
        blue_o  = bytes_i[7:0];
        green_o = bytes_i[15:8];
        red_o   = bytes_i[23:16];
      end
    endcase
  end

endmodule

>>> hdl/bmp_pixel_row_unpacker.sv
// Top level of the BMP pixel row unpacker: stream handshake, palette lookup and result register.
`timescale 1ns / 1ps

// Takes one byte transaction per clock cycle on the input stream, sustained, as long as the
// output side keeps up; after the byte that completes a pixel is accepted, the pixel passes
// through the lookup stage and then the result register. The rate rests on the registered
// palette read: the 1024-byte palette is held in three identical memory copies so blue,
// green and red are fetched in the same cycle. Palette writes (tuser low) never produce a
// result. Writing the mode or width register restarts the row; write configuration only
// while no transaction is in flight. Palette bytes must be written before indexed pixels
// use them.
module bmp_pixel_row_unpacker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bpru_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bpru_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,  // palette_address[9:0], data_byte[17:10]
  input  logic                          s_axis_tuser,  // opcode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [23:0]                   m_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
  output logic                          m_axis_tlast   // row_end
);

  logic                            accept;
  logic                            img_step;
  logic                            pal_we;
  logic [bpru_pkg::PalAddrW-1:0]   in_addr;
  logic [7:0]                      in_data;
  bpru_pkg::pix_info_t             info;
  logic [2:0]                      stride;
  logic [bpru_pkg::PalSpanW-1:0]   pal_base;
  logic [bpru_pkg::PalSpanW-1:0]   pal_addr [3];
  logic [2:0]                      pal_zero;
  logic [7:0]                      pal_rd [3];

  logic                            s1_valid_q, s1_valid_d;
  bpru_pkg::pixel_mode_e           s1_mode_q;
  logic [23:0]                     s1_bytes_q;
  logic                            s1_row_end_q;
  logic [2:0]                      s1_zero_q;
  logic                            s1_move;
  logic                            out_ready;

  logic                            m_valid_q, m_valid_d;
  logic [7:0]                      red, green, blue;
  logic [23:0]                     m_data_q;
  logic                            m_last_q;

  // Handshake: the lookup stage advances when the result register is free or draining.
  assign out_ready     = !m_valid_q || m_axis_tready;
  assign s1_move       = s1_valid_q && out_ready;
  assign s_axis_tready = !s1_valid_q || s1_move;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign img_step      = accept && (s_axis_tuser == bpru_pkg::OP_IMAGE_BYTE);
  assign pal_we        = accept && (s_axis_tuser == bpru_pkg::OP_PAL_WRITE);
  assign in_addr       = s_axis_tdata[9:0];
  assign in_data       = s_axis_tdata[17:10];

  // Row position and configuration.
  bpru_row_ctrl u_row_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (img_step),
    .data_i     (in_data),
    .info_o     (info),
    .stride_o   (stride)
  );

  // Palette addresses of the blue, green and red bytes of an indexed pixel.
  assign pal_base = bpru_pkg::PalSpanW'(in_data) * bpru_pkg::PalSpanW'(stride);

  for (genvar k = 0; k < 3; k++) begin : g_pal
    assign pal_addr[k] = pal_base + bpru_pkg::PalSpanW'(k);
    assign pal_zero[k] = pal_addr[k] >= bpru_pkg::PalSpanW'(bpru_pkg::PaletteBytes);

    bpru_pal_ram u_pal_ram (
      .clk_i   (clk_i),
      .we_i    (pal_we),
      .waddr_i (in_addr),
      .wdata_i (in_data),
      .re_i    (s_axis_tready),
      .raddr_i (pal_addr[k][bpru_pkg::PalAddrW-1:0]),
      .rdata_o (pal_rd[k])
    );
  end

  // Lookup stage: holds a completed pixel while the palette read finishes.
  assign s1_valid_d = s_axis_tready ? (accept && info.emit) : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mode_q    <= info.mode;
      s1_bytes_q   <= info.bytes;
      s1_row_end_q <= info.row_end;
      s1_zero_q    <= pal_zero;
    end
  end

  // Color conversion.
  bpru_pix_decode u_pix_decode (
    .mode_i     (s1_mode_q),
    .bytes_i    (s1_bytes_q),
    .pal_b_i    (pal_rd[0]),
    .pal_g_i    (pal_rd[1]),
    .pal_r_i    (pal_rd[2]),
    .pal_zero_i (s1_zero_q),
    .red_o      (red),
    .green_o    (green),
    .blue_o     (blue)
  );

  // Result register.
  assign m_valid_d = out_ready ? s1_valid_q : m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      m_data_q <= {blue, green, red};
      m_last_q <= s1_row_end_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // A pixel enters the lookup stage only from an accepted image byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s1_valid_q) |-> $past(img_step))
    else $error("lookup stage filled without an image byte");

  // A palette write leaves the lookup stage empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pal_we |=> !s1_valid_q)
    else $error("palette write produced a pixel");

  // A pixel leaving the lookup stage shows up as a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> m_axis_tvalid)
    else $error("pixel lost between lookup and result register");

endmodule
